// ----- sv/clws_pkg.sv -----
// shared types, codes and command tables for the character lcd write sequencer
package clws_pkg;

	localparam int unsigned WAIT_W = 15;
	localparam int unsigned IDX_W = 4;

	// request codes
	localparam logic [1:0] OP_CMD = 2'd0;
	localparam logic [1:0] OP_CHAR = 2'd1;
	localparam logic [1:0] OP_AT_POS = 2'd2;
	localparam logic [1:0] OP_INIT = 2'd3;

	// lcd instruction codes
	localparam logic [7:0] CMD_FUNC_4BIT = 8'h28;
	localparam logic [7:0] CMD_FUNC_8BIT = 8'h38;
	localparam logic [7:0] CMD_CLEAR = 8'h01;
	localparam logic [7:0] CMD_HOME = 8'h02;
	localparam logic [7:0] CMD_ENTRY = 8'h06;
	localparam logic [7:0] CMD_DISP_ON = 8'h0C;
	localparam logic [7:0] CMD_DDRAM_ROW0 = 8'h80;

	// power-up delays
	localparam logic [WAIT_W-1:0] WAIT_POWER_UP = 15'd20000;
	localparam logic [WAIT_W-1:0] WAIT_SECOND = 15'd5000;
	localparam logic [WAIT_W-1:0] WAIT_THIRD = 15'd150;
	localparam logic [WAIT_W-1:0] WAIT_NONE = 15'd0;

	// last byte index of each request kind
	localparam logic [IDX_W-1:0] IDX_FIRST = 4'd0;
	localparam logic [IDX_W-1:0] IDX_SECOND = 4'd1;
	localparam logic [IDX_W-1:0] IDX_INIT_LAST = 4'd8;

	typedef struct packed {
		logic load;
		logic emit;
		logic step;
	} dp_cmd_t;

	typedef struct packed {
		logic last;
	} dp_status_t;

	typedef struct packed {
		logic register_select;
		logic [7:0] bus_value;
		logic [WAIT_W-1:0] wait_before_us;
		logic last;
	} xfer_t;

	function automatic logic [7:0] row_base(input logic [1:0] row);
		logic [7:0] base;
		case (row)
			2'd0: base = 8'h80;
			2'd1: base = 8'hC0;
			2'd2: base = 8'h94;
			default: base = 8'hD4;
		endcase
		return base;
	endfunction

	function automatic logic [7:0] init_cmd(input logic [IDX_W-1:0] idx, input logic mode8);
		logic [7:0] fs;
		logic [7:0] cmd;
		fs = mode8 ? CMD_FUNC_8BIT : CMD_FUNC_4BIT;
		case (idx)
			4'd0, 4'd1, 4'd2, 4'd7: cmd = fs;
			4'd3: cmd = CMD_CLEAR;
			4'd4: cmd = CMD_HOME;
			4'd5: cmd = CMD_ENTRY;
			4'd6: cmd = CMD_DISP_ON;
			default: cmd = CMD_DDRAM_ROW0;
		endcase
		return cmd;
	endfunction

	function automatic logic [WAIT_W-1:0] init_wait(input logic [IDX_W-1:0] idx);
		logic [WAIT_W-1:0] w;
		case (idx)
			4'd0: w = WAIT_POWER_UP;
			4'd1: w = WAIT_SECOND;
			4'd2: w = WAIT_THIRD;
			default: w = WAIT_NONE;
		endcase
		return w;
	endfunction

endpackage

// ----- sv/clws_req_if.sv -----
// request channel: one lcd request per beat
interface clws_req_if;
	logic valid;
	logic ready;
	logic [1:0] op;
	logic [7:0] byte_value;
	logic [2:0] row;
	logic [7:0] column;

	modport source (output valid, output op, output byte_value, output row, output column,
		input ready);
	modport sink (input valid, input op, input byte_value, input row, input column,
		output ready);
endinterface

// ----- sv/clws_xfer_if.sv -----
// transfer channel: one lcd bus transfer per beat
interface clws_xfer_if;
	logic valid;
	logic ready;
	logic register_select;
	logic [7:0] bus_value;
	logic [clws_pkg::WAIT_W-1:0] wait_before_us;
	logic last;

	modport source (output valid, output register_select, output bus_value,
		output wait_before_us, output last, input ready);
	modport sink (input valid, input register_select, input bus_value,
		input wait_before_us, input last, output ready);
endinterface

// ----- sv/char_lcd_write_sequencer.sv -----
// top level of the character lcd write sequencer
// Expands each lcd request (command byte, character byte, character at a row and
// column, or power-up initialization) into the bus transfers the display needs.
// Each transfer beat carries the register-select level, the data-line value and
// the wait in microseconds before its enable strobe; last marks the final beat of
// a request. bus_mode (cfg_we / cfg_wdata, reset 0) picks 4-bit transfers, high
// nibble then low nibble in bits 3..0, or whole 8-bit transfers; write it only
// while no request is in flight. One request is handled at a time: it is accepted,
// then each transfer is prepared and then presented, the present step holding while
// the sink is not ready; a request makes from 1 to 18 transfers. The controller's
// prepare/present loop over the held request sets this sequence.
module char_lcd_write_sequencer (
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input logic cfg_wdata,
	clws_req_if.sink req,
	clws_xfer_if.source xfer
);

	clws_pkg::dp_cmd_t dp_cmd;
	clws_pkg::dp_status_t dp_status;
	clws_pkg::xfer_t dp_xfer;

	// sequencing: accept, then prepare / present each transfer
	clws_ctrl u_ctrl (
		.clk (clk),
		.arst_n (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.xfer_valid (xfer.valid),
		.xfer_ready (xfer.ready),
		.cmd (dp_cmd),
		.status (dp_status)
	);

	// request hold, byte selection, nibble split and output register
	clws_datapath u_datapath (
		.clk (clk),
		.arst_n (arst_n),
		.cfg_we (cfg_we),
		.cfg_wdata (cfg_wdata),
		.op (req.op),
		.byte_value (req.byte_value),
		.row (req.row),
		.column (req.column),
		.cmd (dp_cmd),
		.status (dp_status),
		.xfer (dp_xfer)
	);

	// output beat payload straight from the datapath output register
	assign xfer.register_select = dp_xfer.register_select;
	assign xfer.bus_value = dp_xfer.bus_value;
	assign xfer.wait_before_us = dp_xfer.wait_before_us;
	assign xfer.last = dp_xfer.last;

endmodule

// ----- sv/clws_ctrl.sv -----
// controller state machine for the lcd write sequencer
module clws_ctrl (
	input logic clk,
	input logic arst_n,
	input logic req_valid,
	output logic req_ready,
	output logic xfer_valid,
	input logic xfer_ready,
	output clws_pkg::dp_cmd_t cmd,
	input clws_pkg::dp_status_t status
);

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_PREP = 3'b010,
		ST_SEND = 3'b100
	} state_t;

	state_t state_q;
	state_t state_nxt;

	always_comb begin
		state_nxt = state_q;
		req_ready = 1'b0;
		xfer_valid = 1'b0;
		cmd = '0;
		case (state_q)
			ST_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					cmd.load = 1'b1;
					state_nxt = ST_PREP;
				end
			end
			ST_PREP: begin
				cmd.emit = 1'b1;
				state_nxt = ST_SEND;
			end
			ST_SEND: begin
				xfer_valid = 1'b1;
				if (xfer_ready) begin
					if (status.last) begin
						state_nxt = ST_IDLE;
					end else begin
						cmd.step = 1'b1;
						state_nxt = ST_PREP;
					end
				end
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

endmodule

// ----- sv/clws_datapath.sv -----
// datapath: request hold, byte and nibble sequencing, transfer output register
module clws_datapath (
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input logic cfg_wdata,
	input logic [1:0] op,
	input logic [7:0] byte_value,
	input logic [2:0] row,
	input logic [7:0] column,
	input clws_pkg::dp_cmd_t cmd,
	output clws_pkg::dp_status_t status,
	output clws_pkg::xfer_t xfer
);

	logic mode8_q;
	logic [1:0] op_q;
	logic [7:0] bv_q;
	logic [1:0] row_q;
	logic [7:0] col_q;
	logic [clws_pkg::IDX_W-1:0] idx_q;
	logic half_q;
	clws_pkg::xfer_t xfer_q;

	logic [7:0] cur_byte;
	logic cur_rs;
	logic [clws_pkg::IDX_W-1:0] final_idx;
	logic byte_done;
	clws_pkg::xfer_t xfer_nxt;

	always_comb begin
		cur_byte = bv_q;
		cur_rs = 1'b0;
		final_idx = clws_pkg::IDX_FIRST;
		case (op_q)
			clws_pkg::OP_CMD: begin
				cur_byte = bv_q;
			end
			clws_pkg::OP_CHAR: begin
				cur_rs = 1'b1;
			end
			clws_pkg::OP_AT_POS: begin
				final_idx = clws_pkg::IDX_SECOND;
				cur_rs = idx_q[0];
				// cursor address wraps in eight bits
				cur_byte = idx_q[0] ? bv_q : clws_pkg::row_base(row_q) + col_q;
			end
			clws_pkg::OP_INIT: begin
				final_idx = clws_pkg::IDX_INIT_LAST;
				cur_byte = clws_pkg::init_cmd(idx_q, mode8_q);
			end
			default: begin
				cur_byte = bv_q;
			end
		endcase
	end

	assign byte_done = mode8_q | half_q;

	always_comb begin
		xfer_nxt.register_select = cur_rs;
		if (mode8_q) begin
			xfer_nxt.bus_value = cur_byte;
		end else begin
			xfer_nxt.bus_value = {4'b0000, half_q ? cur_byte[3:0] : cur_byte[7:4]};
		end
		if (op_q == clws_pkg::OP_INIT && !half_q) begin
			xfer_nxt.wait_before_us = clws_pkg::init_wait(idx_q);
		end else begin
			xfer_nxt.wait_before_us = clws_pkg::WAIT_NONE;
		end
		xfer_nxt.last = byte_done && (idx_q == final_idx);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode8_q <= 1'b0;
			idx_q <= '0;
			half_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				mode8_q <= cfg_wdata;
			end
			if (cmd.load) begin
				// an invalid row skips the cursor byte
				idx_q <= (op == clws_pkg::OP_AT_POS && row[2]) ? clws_pkg::IDX_SECOND
					: clws_pkg::IDX_FIRST;
				half_q <= 1'b0;
			end else if (cmd.step) begin
				if (byte_done) begin
					idx_q <= idx_q + 1'b1;
					half_q <= 1'b0;
				end else begin
					half_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q <= op;
			bv_q <= byte_value;
			row_q <= row[1:0];
			col_q <= column;
		end
		if (cmd.emit) begin
			xfer_q <= xfer_nxt;
		end
	end

	assign xfer = xfer_q;
	assign status.last = xfer_q.last;

endmodule
